### hdl/sofl_pkg.sv
package sofl_pkg;

  localparam int MAX_SLOTS_DEF = 1024;

  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 10;
  localparam int OFFSET_W = 25;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 2;
  localparam int USED_W   = 11;
  localparam int GRANTS_W = 32;
  localparam int COUNT_W  = 11;
  localparam int SIZE_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(32);
  localparam logic [USED_W-1:0]  USED_MAX    = '1;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REINIT = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

  // fill levels
  localparam logic [FILL_W-1:0] FILL_EMPTY   = 2'd0;
  localparam logic [FILL_W-1:0] FILL_PARTIAL = 2'd1;
  localparam logic [FILL_W-1:0] FILL_FULL    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE  = 1'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   granted_slot;
    logic [OFFSET_W-1:0] byte_offset;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill_level;
    logic [USED_W-1:0]   slots_in_use;
    logic [GRANTS_W-1:0] total_grants;
  } rsp_t;

endpackage

### hdl/sofl_ram.sv
module sofl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/sofl_offset.sv
module sofl_offset
  import sofl_pkg::*;
#(
  parameter int IDX_W = 10
) (
  input  logic                clk,
  input  logic [IDX_W-1:0]    slot,
  input  logic [SIZE_W-1:0]   size,
  output logic [OFFSET_W-1:0] offset
);

  localparam int PW = IDX_W + SIZE_W;

  logic [PW-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= PW'(slot) * PW'(size);
  end

  // clamp to the largest offset the result can carry
  assign offset = ((prod >> OFFSET_W) != '0) ? '1 : OFFSET_W'(prod);

endmodule

### hdl/slab_object_free_list.sv
// allocate: link read in S_READ, offset multiply in S_MUL, response from S_DONE
// free, unused kind, exhausted allocate: response straight from S_DONE
// reinit: all link entries rewritten, one per cycle through the ram write port
// one request at a time; the next request is taken once the sequencer is back idle
// rst is synchronous; after reset the link chain is rebuilt one entry per cycle with
// requests stalled (configuration writes still taken)
module slab_object_free_list
  import sofl_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int LINK_W = $clog2(MAX_SLOTS + 1);
  localparam int NW     = (LINK_W > COUNT_W) ? LINK_W : COUNT_W;
  localparam int EFF_RESET = (int'(COUNT_RESET) > MAX_SLOTS) ? MAX_SLOTS : int'(COUNT_RESET);
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_SLOTS);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_SLOTS - 1);

  typedef enum logic [4:0] {
    S_SWEEP = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_MUL   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  logic [COUNT_W-1:0]  object_count;
  logic [SIZE_W-1:0]   object_size;
  logic [LINK_W-1:0]   free_head;
  logic [USED_W-1:0]   used_slots;
  logic [GRANTS_W-1:0] grant_counter;
  logic [IDX_W-1:0]    sweep_i;
  logic [LINK_W-1:0]   sweep_n;
  logic                sweep_reply;
  logic [IDX_W-1:0]    grant_idx;
  logic [SLOT_W-1:0]   res_slot;
  logic [OFFSET_W-1:0] res_offset;
  logic [STATUS_W-1:0] res_status;

  logic [NW-1:0]       count_ext;
  logic [LINK_W-1:0]   eff_count;
  logic                accept;
  logic                slot_ok;
  logic                head_end;
  logic [LINK_W-1:0]   sweep_next_link;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [LINK_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [LINK_W-1:0]   ram_rdata;
  logic [OFFSET_W-1:0] mul_offset;
  logic [FILL_W-1:0]   fill;

  // count 0 behaves as one slot, anything above the memory as the memory
  always_comb begin
    count_ext = NW'(object_count);
    if (count_ext == '0) begin
      eff_count = LINK_W'(1);
    end else if (count_ext > NW'(MAX_SLOTS)) begin
      eff_count = END_MARK;
    end else begin
      eff_count = LINK_W'(count_ext);
    end
  end

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign head_end  = (free_head >= END_MARK);
  assign slot_ok   = (NW'(req.slot_index) < NW'(eff_count));

  assign sweep_next_link = ((LINK_W'(sweep_i) + LINK_W'(1)) < sweep_n) ?
                           (LINK_W'(sweep_i) + LINK_W'(1)) : END_MARK;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_i;
    ram_wdata = sweep_next_link;
    if (state == S_SWEEP) begin
      ram_we = 1'b1;
    end else if (accept && req.kind == KIND_FREE && slot_ok) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(req.slot_index);
      ram_wdata = free_head;
    end
  end

  assign ram_re = accept && req.kind == KIND_ALLOC && !head_end;

  sofl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (free_head[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  sofl_offset #(
    .IDX_W (IDX_W)
  ) u_offset (
    .clk    (clk),
    .slot   (grant_idx),
    .size   (object_size),
    .offset (mul_offset)
  );

  always_comb begin
    if (head_end) begin
      fill = FILL_FULL;
    end else if (used_slots == '0) begin
      fill = FILL_EMPTY;
    end else begin
      fill = FILL_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      object_count <= COUNT_RESET;
      object_size  <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OBJECT_COUNT: object_count <= cfg_data[COUNT_W-1:0];
        REG_OBJECT_SIZE:  object_size  <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SWEEP;
      sweep_i       <= '0;
      sweep_n       <= LINK_W'(EFF_RESET);
      sweep_reply   <= 1'b0;
      free_head     <= '0;
      used_slots    <= '0;
      grant_counter <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          sweep_i <= sweep_i + IDX_W'(1);
          if (sweep_i == LAST_IDX) begin
            free_head  <= '0;
            used_slots <= '0;
            res_slot   <= '0;
            res_offset <= '0;
            res_status <= ST_OK;
            state      <= sweep_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_slot   <= '0;
            res_offset <= '0;
            grant_idx  <= free_head[IDX_W-1:0];
            case (req.kind)
              KIND_ALLOC: begin
                if (head_end) begin
                  res_status <= ST_EXHAUSTED;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_READ;
                end
              end
              KIND_FREE: begin
                state <= S_DONE;
                if (slot_ok) begin
                  res_status <= ST_OK;
                  free_head  <= LINK_W'(req.slot_index);
                  if (used_slots != '0) begin
                    used_slots <= used_slots - USED_W'(1);
                  end
                end else begin
                  res_status <= ST_RANGE;
                end
              end
              KIND_REINIT: begin
                res_status  <= ST_OK;
                sweep_i     <= '0;
                sweep_n     <= eff_count;
                sweep_reply <= 1'b1;
                state       <= S_SWEEP;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          // link of the popped slot is on the ram output now
          free_head     <= ram_rdata;
          grant_counter <= grant_counter + GRANTS_W'(1);
          if (used_slots != USED_MAX) begin
            used_slots <= used_slots + USED_W'(1);
          end
          res_slot <= SLOT_W'(grant_idx);
          state    <= S_MUL;
        end
        S_MUL: begin
          res_offset <= mul_offset;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid        <= 1'b1;
            rsp.granted_slot <= res_slot;
            rsp.byte_offset  <= res_offset;
            rsp.status       <= res_status;
            rsp.fill_level   <= fill;
            rsp.slots_in_use <= used_slots;
            rsp.total_grants <= grant_counter;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
